// File: hw/rtl/slot_table_first_free_alloc_defines.svh
// ----------------------------------------------------------------------------
// Slot table assertion macros
// Shorthand for clocked assertions that are disabled while reset is active.
// ----------------------------------------------------------------------------
`ifndef SLOT_TABLE_FIRST_FREE_ALLOC_DEFINES_SVH
`define SLOT_TABLE_FIRST_FREE_ALLOC_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STFF_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("slot table assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define STFF_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("slot table assertion failed");

`endif

// File: hw/rtl/stff_pkg.sv
// ----------------------------------------------------------------------------
// Slot table package
// Shared sizes, command and status codes, and controller/datapath structs.
// ----------------------------------------------------------------------------
package stff_pkg;

  localparam int unsigned CAPACITY       = 64;
  localparam int unsigned IDX_W          = $clog2(CAPACITY);
  localparam int unsigned SIZE_W         = $clog2(CAPACITY + 1);
  localparam int unsigned STATUS_W       = 2;
  localparam int unsigned CMD_W          = 3;
  localparam int unsigned DEF_DATA_WIDTH = 32;

  localparam logic [SIZE_W-1:0] CAP_SIZE = SIZE_W'(CAPACITY);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT_FREE = 3'd0,
    CMD_PUT_AT   = 3'd1,
    CMD_GET      = 3'd2,
    CMD_REMOVE   = 3'd3,
    CMD_FIND     = 3'd4,
    CMD_CHECK    = 3'd5,
    CMD_SET_SIZE = 3'd6,
    CMD_CLEAR    = 3'd7
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_UNUSED = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_ALLOC,
    S_FIND,
    S_GET,
    S_SHRINK,
    S_DONE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load;
    logic    scan_clr;
    logic    scan_load_nsz;
    logic    scan_inc;
    logic    alloc_wr;
    logic    grow;
    logic    put_wr;
    logic    rd_idx;
    logic    find_step;
    logic    cap_rdata;
    logic    remove;
    logic    shrink_step;
    logic    size_set_nsz;
    logic    clear_all;
    logic    set_status;
    status_e status;
    logic    set_hit;
    logic    hit_val;
    logic    set_find_idx;
    logic    commit;
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_e cmd;
    logic in_range;
    logic idx_valid;
    logic scan_end;
    logic scan_valid;
    logic size_full;
    logic nsz_below;
    logic nsz_oor;
    logic find_match;
    logic cmp_pending;
  } stat_t;

endpackage

// File: hw/rtl/stff_ram.sv
// ----------------------------------------------------------------------------
// Slot table RAM
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module stff_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/stff_dp.sv
// ----------------------------------------------------------------------------
// Slot table datapath
// Request latch, valid bits, size and used count, scan pointer, data RAM,
// working result and output payload registers.
// ----------------------------------------------------------------------------
module stff_dp import stff_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [SIZE_W-1:0]     cfg_wdata_i,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [IDX_W-1:0]      slot_index_i,
  input  logic [DATA_WIDTH-1:0] data_value_i,
  input  logic [SIZE_W-1:0]     new_size_i,
  input  ctrl_t                 ctrl_i,
  output stat_t                 stat_o,
  output logic [IDX_W-1:0]      result_index_o,
  output logic [DATA_WIDTH-1:0] result_data_o,
  output logic                  hit_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SIZE_W-1:0]     used_count_o,
  output logic [SIZE_W-1:0]     current_size_o
);

  // Latched request.
  cmd_e                  req_cmd_q;
  logic [IDX_W-1:0]      req_idx_q;
  logic [DATA_WIDTH-1:0] req_val_q;
  logic [SIZE_W-1:0]     nsz_q;
  logic                  nsz_oor_q;

  // Table state.
  logic [CAPACITY-1:0] valid_q, valid_d;
  logic [SIZE_W-1:0]   size_q, size_d;
  logic [SIZE_W-1:0]   used_q, used_d;
  logic [SIZE_W-1:0]   step_q;
  logic [SIZE_W-1:0]   scan_q, scan_d;
  logic                cmp_vld_q, cmp_vld_d;
  logic [IDX_W-1:0]    cmp_idx_q, cmp_idx_d;

  // Working result.
  logic [IDX_W-1:0]      res_index_q, res_index_d;
  logic [DATA_WIDTH-1:0] res_data_q, res_data_d;
  logic                  res_hit_q, res_hit_d;
  status_e               res_status_q, res_status_d;

  // Output payload.
  logic [IDX_W-1:0]      out_index_q;
  logic [DATA_WIDTH-1:0] out_data_q;
  logic                  out_hit_q;
  logic [STATUS_W-1:0]   out_status_q;
  logic [SIZE_W-1:0]     out_used_q;
  logic [SIZE_W-1:0]     out_size_q;

  logic [IDX_W-1:0]      scan_idx;
  logic                  scan_end;
  logic [SIZE_W-1:0]     step_eff;
  logic [SIZE_W:0]       grow_sum;
  logic [SIZE_W-1:0]     grown;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  assign scan_idx = scan_q[IDX_W-1:0];
  assign scan_end = (scan_q >= size_q);

  // Growth by the step, where a zero step counts as one, saturating at capacity.
  assign step_eff = (step_q == '0) ? SIZE_W'(1) : step_q;
  assign grow_sum = {1'b0, size_q} + {1'b0, step_eff};
  assign grown    = (grow_sum > {1'b0, CAP_SIZE}) ? CAP_SIZE : grow_sum[SIZE_W-1:0];

  assign ram_we    = ctrl_i.alloc_wr | ctrl_i.put_wr;
  assign ram_waddr = ctrl_i.alloc_wr ? scan_idx : req_idx_q;
  assign ram_raddr = ctrl_i.rd_idx ? req_idx_q : scan_idx;

  stff_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (req_val_q),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    stat_o             = '0;
    stat_o.cmd         = req_cmd_q;
    stat_o.in_range    = ({1'b0, req_idx_q} < size_q);
    stat_o.idx_valid   = valid_q[req_idx_q];
    stat_o.scan_end    = scan_end;
    stat_o.scan_valid  = valid_q[scan_idx];
    stat_o.size_full   = (size_q == CAP_SIZE);
    stat_o.nsz_below   = (nsz_q < size_q);
    stat_o.nsz_oor     = nsz_oor_q;
    stat_o.find_match  = cmp_vld_q && (ram_rdata == req_val_q);
    stat_o.cmp_pending = cmp_vld_q;
  end

  // Table state updates. Several may be issued together, such as an allocating write with a growth.
  always_comb begin
    valid_d   = valid_q;
    size_d    = size_q;
    used_d    = used_q;
    scan_d    = scan_q;
    cmp_vld_d = cmp_vld_q;
    cmp_idx_d = cmp_idx_q;

    if (ctrl_i.load) begin
      cmp_vld_d = 1'b0;
    end
    if (ctrl_i.scan_clr) begin
      scan_d = '0;
    end
    if (ctrl_i.scan_load_nsz) begin
      scan_d = nsz_q;
    end
    if (ctrl_i.scan_inc) begin
      scan_d = scan_q + SIZE_W'(1);
    end
    if (ctrl_i.alloc_wr) begin
      valid_d[scan_idx] = 1'b1;
      used_d            = used_q + SIZE_W'(1);
    end
    if (ctrl_i.grow) begin
      size_d = grown;
    end
    if (ctrl_i.put_wr) begin
      valid_d[req_idx_q] = 1'b1;
      used_d             = used_q + SIZE_W'(!valid_q[req_idx_q]);
    end
    if (ctrl_i.remove) begin
      valid_d[req_idx_q] = 1'b0;
      used_d             = used_q - SIZE_W'(1);
    end
    if (ctrl_i.find_step) begin
      cmp_vld_d = !scan_end && valid_q[scan_idx];
      cmp_idx_d = scan_idx;
    end
    if (ctrl_i.shrink_step) begin
      valid_d[scan_idx] = 1'b0;
      used_d            = used_q - SIZE_W'(valid_q[scan_idx]);
    end
    if (ctrl_i.size_set_nsz) begin
      size_d = nsz_q;
    end
    if (ctrl_i.clear_all) begin
      valid_d = '0;
      size_d  = '0;
      used_d  = '0;
    end
  end

  always_comb begin
    res_index_d  = res_index_q;
    res_data_d   = res_data_q;
    res_hit_d    = res_hit_q;
    res_status_d = res_status_q;

    if (ctrl_i.load) begin
      res_index_d  = '0;
      res_data_d   = '0;
      res_hit_d    = 1'b0;
      res_status_d = ST_OK;
    end
    if (ctrl_i.set_status) begin
      res_status_d = ctrl_i.status;
    end
    if (ctrl_i.set_hit) begin
      res_hit_d = ctrl_i.hit_val;
    end
    if (ctrl_i.alloc_wr) begin
      res_index_d = scan_idx;
    end
    if (ctrl_i.set_find_idx) begin
      res_index_d = cmp_idx_q;
    end
    if (ctrl_i.cap_rdata) begin
      res_data_d = ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q   <= '0;
      size_q    <= '0;
      used_q    <= '0;
      step_q    <= SIZE_W'(1);
      scan_q    <= '0;
      cmp_vld_q <= 1'b0;
    end else begin
      valid_q   <= valid_d;
      size_q    <= size_d;
      used_q    <= used_d;
      scan_q    <= scan_d;
      cmp_vld_q <= cmp_vld_d;
      if (cfg_we_i) begin
        step_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_idx_q    <= cmp_idx_d;
    res_index_q  <= res_index_d;
    res_data_q   <= res_data_d;
    res_hit_q    <= res_hit_d;
    res_status_q <= res_status_d;
    if (ctrl_i.load) begin
      req_cmd_q <= cmd_e'(command_i);
      req_idx_q <= slot_index_i;
      req_val_q <= data_value_i;
      nsz_q     <= (new_size_i > CAP_SIZE) ? CAP_SIZE : new_size_i;
      nsz_oor_q <= (new_size_i > CAP_SIZE);
    end
    if (ctrl_i.commit) begin
      out_index_q  <= res_index_q;
      out_data_q   <= res_data_q;
      out_hit_q    <= res_hit_q;
      out_status_q <= res_status_q;
      out_used_q   <= used_q;
      out_size_q   <= size_q;
    end
  end

  assign result_index_o = out_index_q;
  assign result_data_o  = out_data_q;
  assign hit_o          = out_hit_q;
  assign status_o       = out_status_q;
  assign used_count_o   = out_used_q;
  assign current_size_o = out_size_q;

endmodule

// File: hw/rtl/stff_ctrl.sv
// ----------------------------------------------------------------------------
// Slot table controller
// Sequences one request at a time through decode, scans and result commit.
// ----------------------------------------------------------------------------
module stff_ctrl import stff_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  output logic  out_valid_o,
  input  logic  out_stall_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_DONE;
        case (stat_i.cmd)
          CMD_PUT_FREE: begin
            ctrl_o.scan_clr = 1'b1;
            state_d         = S_ALLOC;
          end
          CMD_PUT_AT: begin
            if (!stat_i.in_range) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end else begin
              ctrl_o.put_wr = 1'b1;
            end
          end
          CMD_GET: begin
            if (!stat_i.in_range) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end else if (!stat_i.idx_valid) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_UNUSED;
            end else begin
              ctrl_o.rd_idx = 1'b1;
              state_d       = S_GET;
            end
          end
          CMD_REMOVE: begin
            if (!stat_i.in_range) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end else if (!stat_i.idx_valid) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_UNUSED;
            end else begin
              ctrl_o.remove = 1'b1;
            end
          end
          CMD_FIND: begin
            ctrl_o.scan_clr = 1'b1;
            state_d         = S_FIND;
          end
          CMD_CHECK: begin
            ctrl_o.set_hit = 1'b1;
            ctrl_o.hit_val = stat_i.in_range && stat_i.idx_valid;
          end
          CMD_SET_SIZE: begin
            if (stat_i.nsz_oor) begin
              ctrl_o.set_status = 1'b1;
              ctrl_o.status     = ST_RANGE;
            end
            if (stat_i.nsz_below) begin
              ctrl_o.scan_load_nsz = 1'b1;
              state_d              = S_SHRINK;
            end else begin
              ctrl_o.size_set_nsz = 1'b1;
            end
          end
          CMD_CLEAR: begin
            ctrl_o.clear_all = 1'b1;
          end
          default: begin
            state_d = S_DONE;
          end
        endcase
      end

      S_ALLOC: begin
        if (stat_i.scan_end) begin
          if (stat_i.size_full) begin
            ctrl_o.set_status = 1'b1;
            ctrl_o.status     = ST_FULL;
          end else begin
            ctrl_o.alloc_wr = 1'b1;
            ctrl_o.grow     = 1'b1;
          end
          state_d = S_DONE;
        end else if (!stat_i.scan_valid) begin
          ctrl_o.alloc_wr = 1'b1;
          state_d         = S_DONE;
        end else begin
          ctrl_o.scan_inc = 1'b1;
        end
      end

      S_FIND: begin
        if (stat_i.find_match) begin
          ctrl_o.set_hit      = 1'b1;
          ctrl_o.hit_val      = 1'b1;
          ctrl_o.set_find_idx = 1'b1;
          state_d             = S_DONE;
        end else if (stat_i.scan_end && !stat_i.cmp_pending) begin
          state_d = S_DONE;
        end else begin
          ctrl_o.find_step = 1'b1;
          ctrl_o.scan_inc  = !stat_i.scan_end;
        end
      end

      S_GET: begin
        ctrl_o.cap_rdata = 1'b1;
        state_d          = S_DONE;
      end

      S_SHRINK: begin
        if (stat_i.scan_end) begin
          ctrl_o.size_set_nsz = 1'b1;
          state_d             = S_DONE;
        end else begin
          ctrl_o.shrink_step = 1'b1;
          ctrl_o.scan_inc    = 1'b1;
        end
      end

      S_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = ctrl_o.commit ? 1'b1 : (out_valid_q && out_stall_i);

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: hw/rtl/slot_table_first_free_alloc.sv
// ----------------------------------------------------------------------------
// Slot table with first-free allocation
// Put_at, remove, check, clear and a set_size that does not shrink go from
// decode straight to the result; get adds a RAM read. Put_free, find and a
// shrinking set_size walk one slot per cycle, the last clearing each dropped
// slot. One request at a time; the result register lets the next request in
// while a result waits. Reset is immediate.
// ----------------------------------------------------------------------------
module slot_table_first_free_alloc import stff_pkg::*; #(
  parameter int unsigned DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration: the allocation step size.
  input  logic                  cfg_we_i,
  input  logic [SIZE_W-1:0]     cfg_wdata_i,
  // Request channel.
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [CMD_W-1:0]      command_i,
  input  logic [IDX_W-1:0]      slot_index_i,
  input  logic [DATA_WIDTH-1:0] data_value_i,
  input  logic [SIZE_W-1:0]     new_size_i,
  // Result channel.
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [IDX_W-1:0]      result_index_o,
  output logic [DATA_WIDTH-1:0] result_data_o,
  output logic                  hit_o,
  output logic [STATUS_W-1:0]   status_o,
  output logic [SIZE_W-1:0]     used_count_o,
  output logic [SIZE_W-1:0]     current_size_o
);

  // The controller accepts a request only in its idle state and then walks
  // it through decode and, where needed, a scan. Put_free scans the valid
  // bits from slot zero for the first free slot; if none is free below the
  // logical size, the slot at the old size is taken and the size grows by
  // the step, saturating at capacity. Find streams the data RAM one address
  // per cycle and compares each word in the cycle after its read against the
  // searched value, so the scan and the compare overlap.
  //
  // Valid bits above the logical size are always zero: growing therefore
  // needs no clearing, and a shrink clears the dropped slots one per cycle
  // while it keeps the used count exact. The used count is a running counter
  // updated by every write, remove and shrink step, which makes it equal to
  // the number of valid slots below the logical size at all times.
  //
  // The data RAM has no reset. Its words are used only for valid slots, and
  // every valid slot has been written, so no undefined word ever reaches the
  // result.

  stat_t stat;
  ctrl_t ctrl;

  stff_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  stff_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .command_i      (command_i),
    .slot_index_i   (slot_index_i),
    .data_value_i   (data_value_i),
    .new_size_i     (new_size_i),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .result_index_o (result_index_o),
    .result_data_o  (result_data_o),
    .hit_o          (hit_o),
    .status_o       (status_o),
    .used_count_o   (used_count_o),
    .current_size_o (current_size_o)
  );

endmodule

// File: hw/rtl/stff_checker.sv
// ----------------------------------------------------------------------------
// Slot table checker
// Port-level assertions on results of the slot table, bound to the top level.
// ----------------------------------------------------------------------------
`include "slot_table_first_free_alloc_defines.svh"

module stff_checker import stff_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input logic                hit_o,
  input logic [STATUS_W-1:0] status_o,
  input logic [SIZE_W-1:0]   used_count_o,
  input logic [SIZE_W-1:0]   current_size_o
);

  `STFF_ASSERT_IMP(a_used_le_size, out_valid_o, used_count_o <= current_size_o)
  `STFF_ASSERT_IMP(a_size_le_cap, out_valid_o, current_size_o <= CAP_SIZE)
  `STFF_ASSERT_IMP(a_full_at_cap, out_valid_o && status_o == ST_FULL, current_size_o == CAP_SIZE)
  `STFF_ASSERT_IMP(a_hit_is_ok, out_valid_o && hit_o, status_o == ST_OK)
  `STFF_ASSERT_NXT(a_out_held, out_valid_o && out_stall_i, out_valid_o)

endmodule

bind slot_table_first_free_alloc stff_checker u_stff_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .hit_o          (hit_o),
  .status_o       (status_o),
  .used_count_o   (used_count_o),
  .current_size_o (current_size_o)
);

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// Slot table testbench
// Drives command requests into the first-free slot table and checks every
// result, field by field, against a behavioral mirror of the table that is
// kept in step with each accepted request, or against a hand-written one. A
// directed list of requests comes first, then random traffic under several
// allocation steps and varying idle patterns on request and result channels.
// ----------------------------------------------------------------------------
module tb_top;
  import stff_pkg::*;

  localparam int unsigned DW = DEF_DATA_WIDTH;

  // One result as the block reports it.
  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [DW-1:0]     data;
    logic              hit;
    status_e           status;
    logic [SIZE_W-1:0] used;
    logic [SIZE_W-1:0] size;
  } slot_result_t;

  localparam slot_result_t NO_WANT = '0;

  // One row of the directed request list. When known is set, the result is
  // written out by hand; otherwise the mirror decides it.
  typedef struct packed {
    cmd_e              cmd;
    logic [IDX_W-1:0]  idx;
    logic [DW-1:0]     data;
    logic [SIZE_W-1:0] nsz;
    logic              known;
    slot_result_t      want;
  } dir_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic [SIZE_W-1:0] cfg_wdata_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CMD_W-1:0]  command_i = '0;
  logic [IDX_W-1:0]  slot_index_i = '0;
  logic [DW-1:0]     data_value_i = '0;
  logic [SIZE_W-1:0] new_size_i = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [IDX_W-1:0]  result_index_o;
  logic [DW-1:0]     result_data_o;
  logic              hit_o;
  logic [STATUS_W-1:0] status_o;
  logic [SIZE_W-1:0] used_count_o;
  logic [SIZE_W-1:0] current_size_o;

  slot_table_first_free_alloc dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .slot_index_i   (slot_index_i),
    .data_value_i   (data_value_i),
    .new_size_i     (new_size_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_index_o (result_index_o),
    .result_data_o  (result_data_o),
    .hit_o          (hit_o),
    .status_o       (status_o),
    .used_count_o   (used_count_o),
    .current_size_o (current_size_o)
  );

  always #1 clk_i = ~clk_i;

  // Mirror of the table: stored words, valid bits, logical size and the
  // allocation step that the block should currently be using.
  logic [DW-1:0] mirror_data [CAPACITY];
  bit            mirror_valid [CAPACITY];
  int unsigned   mirror_size = 0;
  int unsigned   alloc_step = 1;

  // Results that accepted requests still owe, oldest first.
  slot_result_t  owed_results [$];

  // Idle percentages of both channels and the long result hold-off.
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  bit            hold_request = 1'b0;
  int unsigned   hold_left = 0;

  int unsigned   n_errors = 0;
  int unsigned   n_sent = 0;
  int unsigned   n_checked = 0;
  int unsigned   n_status [4];
  int unsigned   n_find_hits = 0;

  logic [DW-1:0] data_pool [8];

  // Directed requests, issued right after reset with the reset step of one.
  // Rows with hand-written results cover the empty table, the oversized
  // resize, unused-slot accesses and the cleared table.
  dir_row_t dir_rows [25] = '{
    '{CMD_GET,      6'd0,  32'h0,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_RANGE,  7'd0, 7'd0}},
    '{CMD_CHECK,    6'd63, 32'h0,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_OK,     7'd0, 7'd0}},
    '{CMD_REMOVE,   6'd0,  32'h0,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_RANGE,  7'd0, 7'd0}},
    '{CMD_PUT_AT,   6'd0,  32'h5,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_RANGE,  7'd0, 7'd0}},
    '{CMD_FIND,     6'd0,  32'h0,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_OK,     7'd0, 7'd0}},
    '{CMD_PUT_FREE, 6'd63, 32'hFFFFFFFF, 7'd127, 1'b1,
      '{6'd0, 32'h0, 1'b0, ST_OK,     7'd1, 7'd1}},
    '{CMD_SET_SIZE, 6'd0,  32'h0,        7'd127, 1'b1,
      '{6'd0, 32'h0, 1'b0, ST_RANGE,  7'd1, 7'd64}},
    '{CMD_PUT_AT,   6'd63, 32'h0,        7'd0,   1'b0, NO_WANT},
    '{CMD_GET,      6'd63, 32'h0,        7'd0,   1'b0, NO_WANT},
    '{CMD_GET,      6'd0,  32'h0,        7'd0,   1'b0, NO_WANT},
    '{CMD_GET,      6'd1,  32'h0,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_UNUSED, 7'd2, 7'd64}},
    '{CMD_REMOVE,   6'd1,  32'h0,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_UNUSED, 7'd2, 7'd64}},
    '{CMD_FIND,     6'd0,  32'h0,        7'd0,   1'b0, NO_WANT},
    '{CMD_FIND,     6'd0,  32'h12345678, 7'd0,   1'b0, NO_WANT},
    '{CMD_CHECK,    6'd63, 32'h0,        7'd0,   1'b0, NO_WANT},
    '{CMD_PUT_FREE, 6'd0,  32'hA5A5A5A5, 7'd0,   1'b0, NO_WANT},
    '{CMD_REMOVE,   6'd0,  32'h0,        7'd0,   1'b0, NO_WANT},
    '{CMD_PUT_FREE, 6'd0,  32'h5A5A5A5A, 7'd0,   1'b0, NO_WANT},
    '{CMD_SET_SIZE, 6'd0,  32'h0,        7'd64,  1'b0, NO_WANT},
    '{CMD_SET_SIZE, 6'd0,  32'h0,        7'd2,   1'b0, NO_WANT},
    '{CMD_CHECK,    6'd63, 32'h0,        7'd0,   1'b0, NO_WANT},
    '{CMD_SET_SIZE, 6'd0,  32'h0,        7'd0,   1'b0, NO_WANT},
    '{CMD_PUT_FREE, 6'd0,  32'h1,        7'd0,   1'b0, NO_WANT},
    '{CMD_CLEAR,    6'd0,  32'h0,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_OK,     7'd0, 7'd0}},
    '{CMD_PUT_AT,   6'd0,  32'h5,        7'd0,   1'b1,
      '{6'd0, 32'h0, 1'b0, ST_RANGE,  7'd0, 7'd0}}
  };

  // Resizing clears every valid bit between the old and the new size, which
  // covers both the fresh slots of a growth and the dropped ones of a shrink.
  function automatic void resize_mirror(int unsigned sz);
    int unsigned lo;
    int unsigned hi;
    if (sz > CAPACITY) sz = CAPACITY;
    lo = (sz < mirror_size) ? sz : mirror_size;
    hi = (sz < mirror_size) ? mirror_size : sz;
    for (int unsigned i = lo; i < hi; i++) mirror_valid[i] = 1'b0;
    mirror_size = sz;
  endfunction

  // Applies one accepted request to the mirror and returns its result.
  function automatic slot_result_t apply_request(cmd_e cmd, logic [IDX_W-1:0] idx,
                                                 logic [DW-1:0] val,
                                                 logic [SIZE_W-1:0] nsz);
    slot_result_t r;
    int unsigned  slot;
    int unsigned  n_used;
    bit           in_range;
    r = '0;
    r.status = ST_OK;
    in_range = idx < mirror_size;
    case (cmd)
      CMD_PUT_FREE: begin
        slot = CAPACITY;
        for (int unsigned i = 0; i < mirror_size; i++) begin
          if (!mirror_valid[i]) begin
            slot = i;
            break;
          end
        end
        if (slot == CAPACITY && mirror_size >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          // No free slot below the size: grow by the step, a zero step
          // counting as one, and take the first new slot.
          if (slot == CAPACITY) begin
            slot = mirror_size;
            resize_mirror(mirror_size + ((alloc_step == 0) ? 1 : alloc_step));
          end
          mirror_data[slot] = val;
          mirror_valid[slot] = 1'b1;
          r.index = IDX_W'(slot);
        end
      end
      CMD_PUT_AT: begin
        if (!in_range) begin
          r.status = ST_RANGE;
        end else begin
          mirror_data[idx] = val;
          mirror_valid[idx] = 1'b1;
        end
      end
      CMD_GET: begin
        if (!in_range) r.status = ST_RANGE;
        else if (!mirror_valid[idx]) r.status = ST_UNUSED;
        else r.data = mirror_data[idx];
      end
      CMD_REMOVE: begin
        if (!in_range) r.status = ST_RANGE;
        else if (!mirror_valid[idx]) r.status = ST_UNUSED;
        else mirror_valid[idx] = 1'b0;
      end
      CMD_FIND: begin
        for (int unsigned i = 0; i < mirror_size; i++) begin
          if (mirror_valid[i] && mirror_data[i] == val) begin
            r.hit = 1'b1;
            r.index = IDX_W'(i);
            break;
          end
        end
      end
      CMD_CHECK: begin
        r.hit = in_range && mirror_valid[idx];
      end
      CMD_SET_SIZE: begin
        // An oversized request is clamped and flagged as out of range.
        if (nsz > CAPACITY) r.status = ST_RANGE;
        resize_mirror(nsz);
      end
      default: begin
        for (int unsigned i = 0; i < CAPACITY; i++) mirror_valid[i] = 1'b0;
        mirror_size = 0;
      end
    endcase
    n_used = 0;
    for (int unsigned i = 0; i < mirror_size; i++) n_used += mirror_valid[i];
    r.used = SIZE_W'(n_used);
    r.size = SIZE_W'(mirror_size);
    return r;
  endfunction

  // Offers one request, starting at a falling edge, and returns at the
  // falling edge after it is accepted. The sender may idle first. The
  // expected result goes into the queue at the accepting edge.
  task automatic send_request(cmd_e cmd, logic [IDX_W-1:0] idx, logic [DW-1:0] val,
                              logic [SIZE_W-1:0] nsz, bit known, slot_result_t typed);
    slot_result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    command_i    <= cmd;
    slot_index_i <= idx;
    data_value_i <= val;
    new_size_i   <= nsz;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    r = apply_request(cmd, idx, val, nsz);
    n_status[r.status]++;
    if (cmd == CMD_FIND && r.hit) n_find_hits++;
    owed_results.push_back(known ? typed : r);
    n_sent++;
    @(negedge clk_i);
  endtask

  // The step register is only written once the request channel has gone
  // quiet, every owed result has come back and the block has had a few
  // cycles to settle.
  task automatic write_alloc_step(logic [SIZE_W-1:0] v);
    in_valid_i <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    alloc_step = v;
  endtask

  // Random request fields. Values come mostly from a small pool so that
  // finds hit, and indexes mostly fall below the current size.
  function automatic logic [DW-1:0] pick_data();
    if ($urandom_range(99) < 60) return data_pool[$urandom_range(7)];
    return $urandom();
  endfunction

  function automatic logic [IDX_W-1:0] pick_index();
    if (mirror_size > 0 && $urandom_range(99) < 80) return IDX_W'($urandom_range(mirror_size - 1));
    return IDX_W'($urandom_range(CAPACITY - 1));
  endfunction

  // Mostly small sizes keep the scans short; a few go past the capacity.
  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return SIZE_W'($urandom_range(16));
    if (r < 85) return SIZE_W'($urandom_range(CAPACITY));
    return SIZE_W'($urandom_range(127, CAPACITY + 1));
  endfunction

  function automatic cmd_e pick_command();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return CMD_PUT_FREE;
    if (r < 38) return CMD_PUT_AT;
    if (r < 54) return CMD_GET;
    if (r < 66) return CMD_REMOVE;
    if (r < 81) return CMD_FIND;
    if (r < 89) return CMD_CHECK;
    if (r < 97) return CMD_SET_SIZE;
    return CMD_CLEAR;
  endfunction

  // Result side: stalls at random at the configured rate, or for a long
  // counted stretch when the stimulus asks for one, so that the block backs
  // up and stalls its request channel.
  always @(negedge clk_i) begin
    if (hold_request) begin
      hold_left = 400;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic report_field(string what, logic [DW-1:0] want_v, logic [DW-1:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: mismatch in %s: expected %0h, actual %0h", $time, what, want_v, got_v);
      n_errors++;
    end
  endtask

  // Every accepted result is matched against the oldest owed one.
  always @(posedge clk_i) begin : check_results
    slot_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with none owed: index %0h data %0h status %0h",
                 $time, result_index_o, result_data_o, status_o);
        n_errors++;
      end else begin
        want = owed_results.pop_front();
        report_field("result_index", DW'(want.index), DW'(result_index_o));
        report_field("result_data",  want.data,       result_data_o);
        report_field("hit",          DW'(want.hit),   DW'(hit_o));
        report_field("status",       DW'(want.status), DW'(status_o));
        report_field("used_count",   DW'(want.used),  DW'(used_count_o));
        report_field("current_size", DW'(want.size),  DW'(current_size_o));
        n_checked++;
      end
    end
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results still owed.", owed_results.size());
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    logic [SIZE_W-1:0] step_plan [6];
    int unsigned       burst_at;
    int unsigned       n;
    data_pool[0] = '0;
    data_pool[1] = '1;
    for (int i = 2; i < 8; i++) data_pool[i] = $urandom();
    // Zero acts as one, 127 is the widest value, and growth by 64 or 127
    // saturates at the capacity.
    step_plan = '{7'd0, 7'd127, 7'd64, 7'd1, 7'd3, 7'd0};
    step_plan[5] = SIZE_W'($urandom_range(63, 2));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, with the reset step of one and no idling.
    for (int r = 0; r < $size(dir_rows); r++) begin
      send_request(dir_rows[r].cmd, dir_rows[r].idx, dir_rows[r].data, dir_rows[r].nsz,
                   dir_rows[r].known, dir_rows[r].want);
    end

    // Random part in six phases. The first two idle the sender lightly and
    // the receiver heavily, the next two the other way round, the last two
    // not at all. Each phase holds one burst of first-free puts long enough
    // to fill the whole table and then hit the full case.
    for (int ph = 0; ph < 6; ph++) begin
      write_alloc_step(step_plan[ph]);
      send_idle_pct = (ph < 2) ? 32 : (ph < 4) ? 76 : 0;
      recv_idle_pct = (ph < 2) ? 76 : (ph < 4) ? 32 : 0;
      burst_at = $urandom_range(150, 20);
      n = 0;
      while (n < 200) begin
        if (n == burst_at) begin
          // In the first phase without idling, the result side holds off
          // while the burst keeps the request channel busy.
          if (ph == 4) hold_request = 1'b1;
          repeat (66) begin
            send_request(CMD_PUT_FREE, pick_index(), pick_data(), pick_size(), 1'b0, NO_WANT);
            n++;
          end
        end else begin
          send_request(pick_command(), pick_index(), pick_data(), pick_size(), 1'b0, NO_WANT);
          n++;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);

    $display("Ran %0d requests under seven step settings; %0d results checked, %0d finds hit.",
             n_sent, n_checked, n_find_hits);
    $display("Status counts: ok %0d, out of range %0d, unused slot %0d, table full %0d.",
             n_status[ST_OK], n_status[ST_RANGE], n_status[ST_UNUSED], n_status[ST_FULL]);
    if (n_errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches.", n_errors);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/stff_pkg.sv
hw/rtl/stff_ram.sv
hw/rtl/stff_dp.sv
hw/rtl/stff_ctrl.sv
hw/rtl/slot_table_first_free_alloc.sv
hw/rtl/stff_checker.sv
verif/tb_top.sv
